@@ src/srfc_pkg.sv @@
`default_nettype none

package srfc_pkg;

   localparam int unsigned RING_FRAMES_DEF = 1024;
   localparam int unsigned FADE_LENGTH_DEF = 64;
   localparam int unsigned SAMPLE_W        = 16;
   localparam int unsigned FRAME_W         = 2 * SAMPLE_W;
   localparam int unsigned COUNT_W         = 32;
   localparam int unsigned FADE_CNT_W      = 11;

   // action codes
   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_PULL = 1'b1;

   // lane order inside a stereo pair
   localparam int unsigned LANE_LEFT  = 0;
   localparam int unsigned LANE_RIGHT = 1;

   typedef logic [SAMPLE_W-1:0]        sample_type;
   typedef logic [1:0][SAMPLE_W-1:0]   stereo_type;
   typedef logic [COUNT_W-1:0]         count_type;
   typedef logic [FADE_CNT_W-1:0]      fade_cnt_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_FADE,
      ST_FIN
   } state_type;

   typedef struct packed {
      sample_type left_out;
      sample_type right_out;
      logic       evicted;
      logic       skipped_overrun;
      logic       underrun;
      logic       concealing;
      count_type  fill_level;
   } rsp_data_type;

   typedef struct packed {
      logic         valid;
      stereo_type   from_smp;
      stereo_type   x_smp;
      fade_cnt_type w_from;
      fade_cnt_type w_x;
   } fade_req_type;

   typedef struct packed {
      logic       valid;
      stereo_type smp;
   } fade_rsp_type;

endpackage

`default_nettype wire

@@ src/srfc_req_if.sv @@
`default_nettype none

interface srfc_req_if import srfc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       action;
   logic signed [SAMPLE_W-1:0] left_in;
   logic signed [SAMPLE_W-1:0] right_in;
   logic                       block_start;

   modport source (output valid, action, left_in, right_in, block_start, input ready);
   modport sink   (input valid, action, left_in, right_in, block_start, output ready);
endinterface

`default_nettype wire

@@ src/srfc_rsp_if.sv @@
`default_nettype none

interface srfc_rsp_if import srfc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_out;
   logic signed [SAMPLE_W-1:0] right_out;
   logic                       evicted;
   logic                       skipped_overrun;
   logic                       underrun;
   logic                       concealing;
   logic [COUNT_W-1:0]         fill_level;

   modport source (output valid, left_out, right_out, evicted, skipped_overrun, underrun,
                   concealing, fill_level, input ready);
   modport sink   (input valid, left_out, right_out, evicted, skipped_overrun, underrun,
                   concealing, fill_level, output ready);
endinterface

`default_nettype wire

@@ src/srfc_ram.sv @@
`default_nettype none

module srfc_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/srfc_fade.sv @@
`default_nettype none

// four-stage crossfade: products, sum and magnitude, reciprocal multiply, fix-up
module srfc_fade import srfc_pkg::*; #(
   parameter int unsigned FADE_LENGTH = FADE_LENGTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire fade_req_type req,
   output fade_rsp_type      rsp
);

   localparam int unsigned ABS_W   = SAMPLE_W + $clog2(FADE_LENGTH);
   localparam int unsigned RECIP_W = ABS_W + 1;
   localparam int unsigned PROD_W  = SAMPLE_W + FADE_CNT_W + 1;
   localparam int unsigned SUM_W   = PROD_W + 1;
   localparam int unsigned QMUL_W  = ABS_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << ABS_W) / FADE_LENGTH);
   localparam logic [ABS_W-1:0]   LEN   = ABS_W'(FADE_LENGTH);

   logic [3:0] valid_ff, valid_in;

   logic signed [PROD_W-1:0] p_from_ff [2];
   logic signed [PROD_W-1:0] p_from_in [2];
   logic signed [PROD_W-1:0] p_x_ff    [2];
   logic signed [PROD_W-1:0] p_x_in    [2];
   logic [ABS_W-1:0]         mag_ff    [2];
   logic [ABS_W-1:0]         mag_in    [2];
   logic                     neg_ff    [2];
   logic                     neg_in    [2];
   logic [ABS_W-1:0]         mag3_ff   [2];
   logic [ABS_W-1:0]         mag3_in   [2];
   logic                     neg3_ff   [2];
   logic                     neg3_in   [2];
   logic [SAMPLE_W-1:0]      q0_ff     [2];
   logic [SAMPLE_W-1:0]      q0_in     [2];
   stereo_type               res_ff, res_in;

   always_comb begin
      logic signed [PROD_W-1:0] a_ext;
      logic signed [PROD_W-1:0] b_ext;
      logic signed [SUM_W-1:0]  sum;
      logic [SUM_W-1:0]         abs_sum;
      logic [QMUL_W-1:0]        qmul;
      logic [ABS_W-1:0]         qn;
      logic [ABS_W-1:0]         rem;
      logic [SAMPLE_W-1:0]      q;
      valid_in = {valid_ff[2:0], req.valid};
      res_in   = res_ff;
      for (int c = 0; c < 2; c++) begin
         // stage 1: weighted products
         a_ext = {{(PROD_W-SAMPLE_W){req.from_smp[c][SAMPLE_W-1]}}, req.from_smp[c]};
         b_ext = {{(PROD_W-FADE_CNT_W){1'b0}}, req.w_from};
         p_from_in[c] = a_ext * b_ext;
         a_ext = {{(PROD_W-SAMPLE_W){req.x_smp[c][SAMPLE_W-1]}}, req.x_smp[c]};
         b_ext = {{(PROD_W-FADE_CNT_W){1'b0}}, req.w_x};
         p_x_in[c] = a_ext * b_ext;
         // stage 2: sum, split into sign and magnitude
         sum = {p_from_ff[c][PROD_W-1], p_from_ff[c]} + {p_x_ff[c][PROD_W-1], p_x_ff[c]};
         neg_in[c] = sum[SUM_W-1];
         abs_sum   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
         mag_in[c] = abs_sum[ABS_W-1:0];
         // stage 3: quotient estimate, low by at most one
         qmul = QMUL_W'(mag_ff[c]) * QMUL_W'(RECIP);
         q0_in[c]   = qmul[ABS_W +: SAMPLE_W];
         mag3_in[c] = mag_ff[c];
         neg3_in[c] = neg_ff[c];
         // stage 4: remainder check, restore sign
         qn  = ABS_W'(q0_ff[c]) * LEN;
         rem = mag3_ff[c] - qn;
         q   = (rem >= LEN) ? q0_ff[c] + 1'b1 : q0_ff[c];
         if (valid_ff[2]) begin
            res_in[c] = neg3_ff[c] ? SAMPLE_W'(-q) : q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_from_ff <= p_from_in;
      p_x_ff    <= p_x_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      mag3_ff   <= mag3_in;
      neg3_ff   <= neg3_in;
      q0_ff     <= q0_in;
      res_ff    <= res_in;
   end

   assign rsp.valid = valid_ff[3];
   assign rsp.smp   = res_ff;

endmodule

`default_nettype wire

@@ src/stereo_ring_with_fade_concealment_core.sv @@
// a push goes through ST_FIN; a pull reads the registered frame ram in ST_LOAD, then goes to
//   ST_FIN; a faded pull passes ST_LOAD, ST_FADE and ST_FIN, waiting in ST_FADE on the
//   four-stage crossfade multiply/divide unit; only one item is in flight at a time
// a new item is taken while the previous result still waits in the output register
// reset: synchronous, clears both counters, fade and starvation state; the frame ram is
//   not cleared and needs no clearing pass
`default_nettype none

module stereo_ring_with_fade_concealment_core import srfc_pkg::*; #(
   parameter int unsigned RING_FRAMES = RING_FRAMES_DEF,
   parameter int unsigned FADE_LENGTH = FADE_LENGTH_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   srfc_req_if.sink   req_ch,
   srfc_rsp_if.source rsp_ch
);

   localparam int unsigned AW   = $clog2(RING_FRAMES);
   localparam count_type   RING = COUNT_W'(RING_FRAMES);
   localparam fade_cnt_type LEN = FADE_CNT_W'(FADE_LENGTH);

   state_type    state_ff, state_in;
   count_type    wc_ff, wc_in;
   count_type    rc_ff, rc_in;
   stereo_type   fade_start_ff, fade_start_in;
   stereo_type   last_ff, last_in;
   fade_cnt_type flc_ff, flc_in;
   logic         starving_ff, starving_in;
   logic         primed_ff, primed_in;
   logic         out_valid_ff, out_valid_in;

   logic         have_ff, have_in;
   logic         conceal_ff, conceal_in;
   fade_cnt_type wfrom_ff, wfrom_in;
   fade_cnt_type wx_ff, wx_in;
   rsp_data_type res_ff, res_in;
   rsp_data_type out_ff, out_in;

   logic         ready;
   logic         accept;
   logic         launch;
   logic         load_out;
   logic         mem_wr_en;
   logic         mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [FRAME_W-1:0] mem_rd_data;
   stereo_type   x_smp;
   fade_req_type fade_req;
   fade_rsp_type fade_rsp;

   srfc_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (RING_FRAMES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wc_ff[AW-1:0]),
      .wr_data ({req_ch.right_in, req_ch.left_in}),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   srfc_fade #(
      .FADE_LENGTH (FADE_LENGTH)
   ) u_fade (
      .clock (clock),
      .reset (reset),
      .req   (fade_req),
      .rsp   (fade_rsp)
   );

   // control outputs
   always_comb begin
      ready     = (state_ff == ST_IDLE);
      accept    = ready && req_ch.valid;
      mem_wr_en = accept && (req_ch.action == ACT_PUSH);
      mem_rd_en = accept && (req_ch.action == ACT_PULL);
      launch    = (state_ff == ST_LOAD) && conceal_ff;
      load_out  = (state_ff == ST_FIN) && (!out_valid_ff || rsp_ch.ready);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_ch.action == ACT_PUSH) ? ST_FIN : ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = conceal_ff ? ST_FADE : ST_FIN;
         end
         ST_FADE: begin
            if (fade_rsp.valid) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      x_smp[LANE_LEFT]  = have_ff ? mem_rd_data[SAMPLE_W-1:0] : '0;
      x_smp[LANE_RIGHT] = have_ff ? mem_rd_data[FRAME_W-1:SAMPLE_W] : '0;
      fade_req.valid    = launch;
      fade_req.from_smp = fade_start_ff;
      fade_req.x_smp    = x_smp;
      fade_req.w_from   = wfrom_ff;
      fade_req.w_x      = wx_ff;
   end

   // datapath
   always_comb begin
      count_type    fill;
      count_type    fill_eff;
      count_type    tail;
      logic         skip;
      logic         have;
      logic         arm;
      fade_cnt_type flc_eff;
      fill     = wc_ff - rc_ff;
      skip     = req_ch.block_start && (fill > RING);
      tail     = skip ? wc_ff - RING : rc_ff;
      fill_eff = skip ? RING : fill;
      have     = (fill_eff != '0);
      arm      = (skip && primed_ff) || (have && starving_ff) || (!have && !starving_ff);
      flc_eff  = arm ? LEN : flc_ff;
      mem_rd_addr = tail[AW-1:0];

      wc_in         = wc_ff;
      rc_in         = rc_ff;
      fade_start_in = fade_start_ff;
      last_in       = last_ff;
      flc_in        = flc_ff;
      starving_in   = starving_ff;
      primed_in     = primed_ff;
      have_in       = have_ff;
      conceal_in    = conceal_ff;
      wfrom_in      = wfrom_ff;
      wx_in         = wx_ff;
      res_in        = res_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;

      if (accept) begin
         res_in = '0;
         if (req_ch.action == ACT_PUSH) begin
            wc_in             = wc_ff + 1'b1;
            res_in.evicted    = (fill >= RING);
            res_in.fill_level = wc_in - rc_ff;
         end else begin
            rc_in       = have ? tail + 1'b1 : tail;
            starving_in = !have;
            primed_in   = primed_ff || have;
            if (arm) begin
               fade_start_in = last_ff;
            end
            have_in    = have;
            conceal_in = (flc_eff != '0);
            flc_in     = (flc_eff != '0) ? flc_eff - 1'b1 : flc_eff;
            wfrom_in   = flc_eff - 1'b1;
            wx_in      = LEN - flc_eff + 1'b1;
            res_in.skipped_overrun = skip;
            res_in.underrun        = !have && !starving_ff && primed_ff;
            res_in.concealing      = (flc_eff != '0);
            res_in.fill_level      = wc_ff - rc_in;
         end
      end

      // plain pull takes the frame straight from the ram
      if ((state_ff == ST_LOAD) && !conceal_ff) begin
         res_in.left_out  = x_smp[LANE_LEFT];
         res_in.right_out = x_smp[LANE_RIGHT];
         last_in          = x_smp;
      end
      if ((state_ff == ST_FADE) && fade_rsp.valid) begin
         res_in.left_out  = fade_rsp.smp[LANE_LEFT];
         res_in.right_out = fade_rsp.smp[LANE_RIGHT];
         last_in          = fade_rsp.smp;
      end

      if (load_out) begin
         out_in       = res_ff;
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wc_ff         <= '0;
         rc_ff         <= '0;
         fade_start_ff <= '0;
         last_ff       <= '0;
         flc_ff        <= '0;
         starving_ff   <= 1'b0;
         primed_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wc_ff         <= wc_in;
         rc_ff         <= rc_in;
         fade_start_ff <= fade_start_in;
         last_ff       <= last_in;
         flc_ff        <= flc_in;
         starving_ff   <= starving_in;
         primed_ff     <= primed_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      have_ff    <= have_in;
      conceal_ff <= conceal_in;
      wfrom_ff   <= wfrom_in;
      wx_ff      <= wx_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

   assign req_ch.ready           = ready;
   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.left_out        = out_ff.left_out;
   assign rsp_ch.right_out       = out_ff.right_out;
   assign rsp_ch.evicted         = out_ff.evicted;
   assign rsp_ch.skipped_overrun = out_ff.skipped_overrun;
   assign rsp_ch.underrun        = out_ff.underrun;
   assign rsp_ch.concealing      = out_ff.concealing;
   assign rsp_ch.fill_level      = out_ff.fill_level;

endmodule

`default_nettype wire

@@ src/srfc_checker.sv @@
`default_nettype none

module srfc_checker import srfc_pkg::*; #(
   parameter int unsigned RING_FRAMES = RING_FRAMES_DEF
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [SAMPLE_W-1:0] left_out,
   input wire logic [SAMPLE_W-1:0] right_out,
   input wire logic               evicted,
   input wire logic               skipped_overrun,
   input wire logic               underrun,
   input wire logic               concealing,
   input wire logic [COUNT_W-1:0] fill_level
);

   localparam logic [COUNT_W-1:0] RING_LESS_ONE = COUNT_W'(RING_FRAMES - 1);

   // one item in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again right after an accept");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(left_out) && $stable(right_out)
         && $stable(fill_level) && $stable(evicted))
      else $error("stalled result changed");

   // an eviction only comes from a push, which carries no pull flags or samples
   a_evict_is_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && evicted |-> left_out == '0 && right_out == '0 && !skipped_overrun
         && !underrun && !concealing)
      else $error("eviction flagged on a pull result");

   a_underrun_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && underrun |-> fill_level == '0)
      else $error("underrun with frames left in the ring");

   // a skip leaves a full ring, then one frame is read
   a_skip_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && skipped_overrun |-> fill_level == RING_LESS_ONE)
      else $error("fill level wrong after overrun skip");

endmodule

bind stereo_ring_with_fade_concealment_core srfc_checker #(
   .RING_FRAMES (RING_FRAMES)
) u_srfc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .left_out        (rsp_ch.left_out),
   .right_out       (rsp_ch.right_out),
   .evicted         (rsp_ch.evicted),
   .skipped_overrun (rsp_ch.skipped_overrun),
   .underrun        (rsp_ch.underrun),
   .concealing      (rsp_ch.concealing),
   .fill_level      (rsp_ch.fill_level)
);

`default_nettype wire
